/* design/chebyshev_interpolation_weight_defines.svh */
// Assertion macros for the Chebyshev interpolation weight block.
// Included by the top level; no other dependencies.
`ifndef CHEBYSHEV_INTERPOLATION_WEIGHT_DEFINES_SVH
`define CHEBYSHEV_INTERPOLATION_WEIGHT_DEFINES_SVH
`ifndef SYNTH
`define CIW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ciw: assertion failed");
`define CIW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ciw: assertion failed");
`else
`define CIW_ASSERT_IMP(label, clk, rst, ante, cons)
`define CIW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/ciw_pkg.sv */
// Shared types, constants and saturation helper for the interpolation weight block.
// No dependencies.
`default_nettype none
package ciw_pkg;

   localparam int ORDER_DEFAULT = 8;
   localparam int ACC_W         = 49;   // sum width, enough for ORDER up to 16
   localparam int CSR_IDX_W     = 3;

   localparam logic signed [31:0] QONE = 32'sd16777216;  // 1.0 in Q8.24

   localparam logic [1:0] OP_WEIGHT    = 2'd0;
   localparam logic [1:0] OP_DERIV     = 2'd1;
   localparam logic [1:0] OP_NEG_DERIV = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

   localparam logic [30:0] SCALE_RESET = 31'd65536;

   // per-axis sideband that rides along the axis pipeline
   typedef struct packed {
      logic [1:0]          opcode;
      logic signed [31:0]  normal;
   } side_type;

   typedef struct packed {
      logic                flag;
      logic signed [31:0]  value;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sd2147483647) begin
         r.flag  = 1'b1;
         r.value = {1'b0, {31{1'b1}}};
      end else if (v < -64'sd2147483648) begin
         r.flag  = 1'b1;
         r.value = {1'b1, 31'd0};
      end else begin
         r.flag  = 1'b0;
         r.value = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/ciw_div.sv */
// Pipelined signed divide by ORDER (truncating), then >>>4 and clip to 32 bits.
// Uses ciw_pkg; one 16-bit chunk of the magnitude per stage via reciprocal multiply.
`default_nettype none
module ciw_div #(
   parameter int ORDER  = ciw_pkg::ORDER_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [ciw_pkg::ACC_W-1:0] in_value,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic signed [31:0]          out_value,
   output logic                        out_flag,
   output logic [SIDE_W-1:0]           out_side
);
   import ciw_pkg::*;

   localparam int MAG_W   = ACC_W - 1;
   localparam int CHUNK_W = 16;
   localparam int N_CHUNK = MAG_W / CHUNK_W;
   localparam int REM_W   = $clog2(ORDER);
   localparam int V_W     = REM_W + CHUNK_W;
   localparam int SH      = V_W + REM_W + 1;
   localparam int MUL_W   = SH + 1;
   localparam longint MUL = ((longint'(1) <<< SH) + longint'(ORDER) - 1) / longint'(ORDER);
   localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL);

   logic              v_ff    [N_CHUNK+1];
   logic              v_in    [N_CHUNK+1];
   logic              neg_ff  [N_CHUNK+1];
   logic              neg_in  [N_CHUNK+1];
   logic [MAG_W-1:0]  mag_ff  [N_CHUNK+1];
   logic [MAG_W-1:0]  mag_in  [N_CHUNK+1];
   logic [MAG_W-1:0]  quo_ff  [N_CHUNK+1];
   logic [MAG_W-1:0]  quo_in  [N_CHUNK+1];
   logic [REM_W-1:0]  rem_ff  [N_CHUNK+1];
   logic [REM_W-1:0]  rem_in  [N_CHUNK+1];
   logic [SIDE_W-1:0] side_ff [N_CHUNK+1];
   logic [SIDE_W-1:0] side_in [N_CHUNK+1];

   logic signed [ACC_W-1:0] abs_val;

   // magnitude and sign
   always_comb begin
      abs_val    = in_value[ACC_W-1] ? -in_value : in_value;
      v_in[0]    = in_valid;
      neg_in[0]  = in_value[ACC_W-1];
      mag_in[0]  = abs_val[MAG_W-1:0];
      quo_in[0]  = '0;
      rem_in[0]  = '0;
      side_in[0] = in_side;
   end

   for (genvar c = 0; c < N_CHUNK; c++) begin : g_chunk
      logic [V_W-1:0]       dvd;
      logic [V_W+MUL_W-1:0] prod;
      logic [CHUNK_W-1:0]   q;
      logic [V_W-1:0]       r;

      always_comb begin
         dvd  = {rem_ff[c], mag_ff[c][MAG_W-1-c*CHUNK_W -: CHUNK_W]};
         prod = (V_W+MUL_W)'(dvd) * (V_W+MUL_W)'(MUL_C);
         q    = CHUNK_W'(prod >> SH);
         r    = dvd - V_W'(q) * V_W'(ORDER);
         if (r >= V_W'(ORDER)) begin
            q = q + 1'b1;
            r = r - V_W'(ORDER);
         end
         v_in[c+1]    = v_ff[c];
         neg_in[c+1]  = neg_ff[c];
         mag_in[c+1]  = mag_ff[c];
         quo_in[c+1]  = {quo_ff[c][MAG_W-CHUNK_W-1:0], q};
         rem_in[c+1]  = REM_W'(r);
         side_in[c+1] = side_ff[c];
      end
   end

   for (genvar s = 0; s <= N_CHUNK; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_in[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s]  <= neg_in[s];
            mag_ff[s]  <= mag_in[s];
            quo_ff[s]  <= quo_in[s];
            rem_ff[s]  <= rem_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   // sign, shift, clip
   logic signed [ACC_W-1:0] qs;
   sat_type                 res;
   logic                    ov_ff, ov_in;
   logic signed [31:0]      val_ff, val_in;
   logic                    fl_ff, fl_in;
   logic [SIDE_W-1:0]       os_ff, os_in;

   always_comb begin
      qs     = neg_ff[N_CHUNK] ? -$signed({1'b0, quo_ff[N_CHUNK]})
                               : $signed({1'b0, quo_ff[N_CHUNK]});
      res    = sat32(64'(qs >>> 4));
      ov_in  = v_ff[N_CHUNK];
      val_in = res.value;
      fl_in  = res.flag;
      os_in  = side_ff[N_CHUNK];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff <= val_in;
         fl_ff  <= fl_in;
         os_ff  <= os_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_value = val_ff;
   assign out_flag  = fl_ff;
   assign out_side  = os_ff;

endmodule
`default_nettype wire

/* design/ciw_axis.sv */
// One axis: map the point into the box frame, run the Chebyshev recurrences one
// term per stage, then divide the sums. Uses ciw_pkg and ciw_div.
`default_nettype none
module ciw_axis #(
   parameter int ORDER = ciw_pkg::ORDER_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [31:0]  point,
   input  logic signed [31:0]  centre,
   input  logic [30:0]         scale,
   input  logic signed [31:0]  node,
   input  ciw_pkg::side_type   in_side,
   output logic                out_valid,
   output logic signed [31:0]  s_value,
   output logic signed [31:0]  ds_value,
   output logic                out_flag,
   output ciw_pkg::side_type   out_side
);
   import ciw_pkg::*;

   localparam int SW = $bits(side_type) + 1;

   // stage 0: offset from centre, node to Q8.24
   logic               v0_ff, v0_in;
   logic signed [32:0] d0_ff, d0_in;
   logic signed [31:0] nd0_ff, nd0_in;
   side_type           side0_ff, side0_in;

   always_comb begin
      v0_in    = in_valid;
      d0_in    = 33'(point) - 33'(centre);
      nd0_in   = node >>> 6;
      side0_in = in_side;
   end

   // stage 1: scale product
   logic               v1_ff, v1_in;
   logic signed [64:0] prod1_ff, prod1_in;
   logic signed [31:0] nd1_ff, nd1_in;
   side_type           side1_ff, side1_in;

   always_comb begin
      v1_in    = v0_ff;
      prod1_in = d0_ff * $signed({1'b0, scale});
      nd1_in   = nd0_ff;
      side1_in = side0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff    <= d0_in;
         nd0_ff   <= nd0_in;
         side0_ff <= side0_in;
         prod1_ff <= prod1_in;
         nd1_ff   <= nd1_in;
         side1_ff <= side1_in;
      end
   end

   // recurrence pipeline; entry 0 holds the order-1 seeds
   logic                    v_ff    [ORDER];
   logic                    v_in    [ORDER];
   logic signed [31:0]      x_ff    [ORDER];
   logic signed [31:0]      x_in    [ORDER];
   logic signed [31:0]      nd_ff   [ORDER];
   logic signed [31:0]      nd_in   [ORDER];
   logic signed [31:0]      txp_ff  [ORDER];
   logic signed [31:0]      txp_in  [ORDER];
   logic signed [31:0]      txc_ff  [ORDER];
   logic signed [31:0]      txc_in  [ORDER];
   logic signed [31:0]      tcp_ff  [ORDER];
   logic signed [31:0]      tcp_in  [ORDER];
   logic signed [31:0]      tcc_ff  [ORDER];
   logic signed [31:0]      tcc_in  [ORDER];
   logic signed [31:0]      uxp_ff  [ORDER];
   logic signed [31:0]      uxp_in  [ORDER];
   logic signed [31:0]      uxc_ff  [ORDER];
   logic signed [31:0]      uxc_in  [ORDER];
   logic signed [ACC_W-1:0] acc_ff  [ORDER];
   logic signed [ACC_W-1:0] acc_in  [ORDER];
   logic signed [ACC_W-1:0] dacc_ff [ORDER];
   logic signed [ACC_W-1:0] dacc_in [ORDER];
   logic                    fs_ff   [ORDER];
   logic                    fs_in   [ORDER];
   logic                    fd_ff   [ORDER];
   logic                    fd_in   [ORDER];
   side_type                side_ff [ORDER];
   side_type                side_in [ORDER];

   sat_type xs, us;

   always_comb begin
      xs         = sat32(64'(prod1_ff >>> 8));
      us         = sat32(64'(xs.value) + 64'(xs.value));
      v_in[0]    = v1_ff;
      x_in[0]    = xs.value;
      nd_in[0]   = nd1_ff;
      txp_in[0]  = QONE;
      txc_in[0]  = xs.value;
      tcp_in[0]  = QONE;
      tcc_in[0]  = nd1_ff;
      uxp_in[0]  = QONE;
      uxc_in[0]  = us.value;
      acc_in[0]  = ACC_W'(QONE);
      dacc_in[0] = '0;
      fs_in[0]   = xs.flag;
      fd_in[0]   = us.flag;
      side_in[0] = side1_ff;
   end

   // stage i adds term j = i+1 and steps the recurrences to order i+2
   for (genvar i = 0; i < ORDER - 1; i++) begin : g_term
      logic signed [63:0] ptx, ptc, pux, pt, pd;
      sat_type            ntx, ntc, nux;

      always_comb begin
         ptx = x_ff[i] * txc_ff[i];
         ptc = nd_ff[i] * tcc_ff[i];
         pux = x_ff[i] * uxc_ff[i];
         pt  = tcc_ff[i] * txc_ff[i];
         pd  = tcc_ff[i] * uxp_ff[i];
         ntx = sat32((ptx >>> 23) - 64'(txp_ff[i]));
         ntc = sat32((ptc >>> 23) - 64'(tcp_ff[i]));
         nux = sat32((pux >>> 23) - 64'(uxp_ff[i]));
         v_in[i+1]    = v_ff[i];
         x_in[i+1]    = x_ff[i];
         nd_in[i+1]   = nd_ff[i];
         txp_in[i+1]  = txc_ff[i];
         txc_in[i+1]  = ntx.value;
         tcp_in[i+1]  = tcc_ff[i];
         tcc_in[i+1]  = ntc.value;
         uxp_in[i+1]  = uxc_ff[i];
         uxc_in[i+1]  = nux.value;
         acc_in[i+1]  = acc_ff[i] + (ACC_W'(pt >>> 24) <<< 1);
         dacc_in[i+1] = dacc_ff[i] + ACC_W'(pd >>> 24) * ACC_W'(2 * (i + 1));
         fs_in[i+1]   = fs_ff[i];
         fd_in[i+1]   = fd_ff[i];
         if (i < ORDER - 2) begin
            fs_in[i+1] = fs_ff[i] | ntx.flag | ntc.flag;
            fd_in[i+1] = fd_ff[i] | nux.flag;
         end
         side_in[i+1] = side_ff[i];
      end
   end

   for (genvar s = 0; s < ORDER; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_in[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]    <= x_in[s];
            nd_ff[s]   <= nd_in[s];
            txp_ff[s]  <= txp_in[s];
            txc_ff[s]  <= txc_in[s];
            tcp_ff[s]  <= tcp_in[s];
            tcc_ff[s]  <= tcc_in[s];
            uxp_ff[s]  <= uxp_in[s];
            uxc_ff[s]  <= uxc_in[s];
            acc_ff[s]  <= acc_in[s];
            dacc_ff[s] <= dacc_in[s];
            fs_ff[s]   <= fs_in[s];
            fd_ff[s]   <= fd_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   // second-kind terms only count for the gradient opcodes
   logic          want_d;
   logic          f_axis;
   logic [SW-1:0] s_side_out;
   logic          d_want_out;
   logic          s_valid, d_valid, s_clip, d_clip;

   assign want_d = (side_ff[ORDER-1].opcode == OP_DERIV) ||
                   (side_ff[ORDER-1].opcode == OP_NEG_DERIV);
   assign f_axis = fs_ff[ORDER-1] | (want_d & fd_ff[ORDER-1]);

   ciw_div #(.ORDER(ORDER), .SIDE_W(SW)) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[ORDER-1]),
      .in_value  (acc_ff[ORDER-1]),
      .in_side   ({f_axis, side_ff[ORDER-1]}),
      .out_valid (s_valid),
      .out_value (s_value),
      .out_flag  (s_clip),
      .out_side  (s_side_out)
   );

   ciw_div #(.ORDER(ORDER), .SIDE_W(1)) u_div_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[ORDER-1]),
      .in_value  (dacc_ff[ORDER-1]),
      .in_side   (want_d),
      .out_valid (d_valid),
      .out_value (ds_value),
      .out_flag  (d_clip),
      .out_side  (d_want_out)
   );

   assign out_valid = s_valid & d_valid;
   assign out_side  = side_type'(s_side_out[SW-2:0]);
   assign out_flag  = s_side_out[SW-1] | s_clip | (d_want_out & d_clip);

endmodule
`default_nettype wire

/* design/ciw_comb.sv */
// Combines the per-axis weights: triple products, normal weighting, scale, sum,
// opcode select and the output register. Uses ciw_pkg.
`default_nettype none
module ciw_comb (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [31:0]  sx,
   input  logic signed [31:0]  sy,
   input  logic signed [31:0]  sz,
   input  logic signed [31:0]  dx,
   input  logic signed [31:0]  dy,
   input  logic signed [31:0]  dz,
   input  logic                in_flag,
   input  logic [1:0]          opcode,
   input  logic signed [31:0]  normal_x,
   input  logic signed [31:0]  normal_y,
   input  logic signed [31:0]  normal_z,
   input  logic [30:0]         scale_x,
   input  logic [30:0]         scale_y,
   input  logic [30:0]         scale_z,
   output logic                out_valid,
   output logic signed [31:0]  weight_value,
   output logic                saturated
);
   import ciw_pkg::*;

   // stage 1: pairwise products
   logic               v1_ff, v1_in;
   logic [1:0]         op1_ff, op1_in;
   logic signed [31:0] a0_ff, a0_in, a1_ff, a1_in, a2_ff, a2_in;
   logic signed [31:0] sz1_ff, sz1_in, dz1_ff, dz1_in;
   logic signed [31:0] nx1_ff, nx1_in, ny1_ff, ny1_in, nz1_ff, nz1_in;
   logic               fw1_ff, fw1_in, fg1_ff, fg1_in;
   logic signed [63:0] p0, p1, p2;
   sat_type            r0, r1, r2;

   always_comb begin
      p0     = sx * sy;
      p1     = dx * sy;
      p2     = sx * dy;
      r0     = sat32(p0 >>> 20);
      r1     = sat32(p1 >>> 20);
      r2     = sat32(p2 >>> 20);
      v1_in  = in_valid;
      op1_in = opcode;
      a0_in  = r0.value;
      a1_in  = r1.value;
      a2_in  = r2.value;
      sz1_in = sz;
      dz1_in = dz;
      nx1_in = normal_x;
      ny1_in = normal_y;
      nz1_in = normal_z;
      fw1_in = in_flag | r0.flag;
      fg1_in = in_flag | r0.flag | r1.flag | r2.flag;
   end

   // stage 2: triple products
   logic               v2_ff, v2_in;
   logic [1:0]         op2_ff, op2_in;
   logic signed [31:0] tw2_ff, tw2_in, g0_ff, g0_in, g1_ff, g1_in, g2_ff, g2_in;
   logic signed [31:0] nx2_ff, nx2_in, ny2_ff, ny2_in, nz2_ff, nz2_in;
   logic               fw2_ff, fw2_in, fg2_ff, fg2_in;
   logic signed [63:0] q0, q1, q2, q3;
   sat_type            t0, t1, t2, t3;

   always_comb begin
      q0     = a0_ff * sz1_ff;
      q1     = a1_ff * sz1_ff;
      q2     = a2_ff * sz1_ff;
      q3     = a0_ff * dz1_ff;
      t0     = sat32(q0 >>> 20);
      t1     = sat32(q1 >>> 20);
      t2     = sat32(q2 >>> 20);
      t3     = sat32(q3 >>> 20);
      v2_in  = v1_ff;
      op2_in = op1_ff;
      tw2_in = t0.value;
      g0_in  = t1.value;
      g1_in  = t2.value;
      g2_in  = t3.value;
      nx2_in = nx1_ff;
      ny2_in = ny1_ff;
      nz2_in = nz1_ff;
      fw2_in = fw1_ff | t0.flag;
      fg2_in = fg1_ff | t1.flag | t2.flag | t3.flag;
   end

   // stage 3: normal weighting
   logic               v3_ff, v3_in;
   logic [1:0]         op3_ff, op3_in;
   logic signed [31:0] tw3_ff, tw3_in, e0_ff, e0_in, e1_ff, e1_in, e2_ff, e2_in;
   logic               fw3_ff, fw3_in, fg3_ff, fg3_in;
   logic signed [63:0] n0, n1, n2;
   sat_type            k0, k1, k2;

   always_comb begin
      n0     = nx2_ff * g0_ff;
      n1     = ny2_ff * g1_ff;
      n2     = nz2_ff * g2_ff;
      k0     = sat32(n0 >>> 30);
      k1     = sat32(n1 >>> 30);
      k2     = sat32(n2 >>> 30);
      v3_in  = v2_ff;
      op3_in = op2_ff;
      tw3_in = tw2_ff;
      e0_in  = k0.value;
      e1_in  = k1.value;
      e2_in  = k2.value;
      fw3_in = fw2_ff;
      fg3_in = fg2_ff | k0.flag | k1.flag | k2.flag;
   end

   // stage 4: per-axis scale
   logic               v4_ff, v4_in;
   logic [1:0]         op4_ff, op4_in;
   logic signed [31:0] tw4_ff, tw4_in;
   logic signed [42:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic               fw4_ff, fw4_in, fg4_ff, fg4_in;
   logic signed [62:0] c0, c1, c2;

   always_comb begin
      c0     = e0_ff * $signed({1'b0, scale_x});
      c1     = e1_ff * $signed({1'b0, scale_y});
      c2     = e2_ff * $signed({1'b0, scale_z});
      v4_in  = v3_ff;
      op4_in = op3_ff;
      tw4_in = tw3_ff;
      m0_in  = 43'(c0 >>> 20);
      m1_in  = 43'(c1 >>> 20);
      m2_in  = 43'(c2 >>> 20);
      fw4_in = fw3_ff;
      fg4_in = fg3_ff;
   end

   // output register: sum, sign, select
   logic               ov_ff, ov_in;
   logic signed [31:0] w_ff, w_in;
   logic               sat_ff, sat_in;
   logic signed [44:0] sum;
   sat_type            gs;

   always_comb begin
      sum = 45'(m0_ff) + 45'(m1_ff) + 45'(m2_ff);
      if (op4_ff == OP_NEG_DERIV) begin
         sum = -sum;
      end
      gs    = sat32(64'(sum));
      ov_in = v4_ff;
      case (op4_ff)
         OP_WEIGHT: begin
            w_in   = tw4_ff >>> 4;
            sat_in = fw4_ff;
         end
         OP_DERIV, OP_NEG_DERIV: begin
            w_in   = gs.value;
            sat_in = fg4_ff | gs.flag;
         end
         default: begin
            w_in   = '0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= op1_in;
         a0_ff  <= a0_in;
         a1_ff  <= a1_in;
         a2_ff  <= a2_in;
         sz1_ff <= sz1_in;
         dz1_ff <= dz1_in;
         nx1_ff <= nx1_in;
         ny1_ff <= ny1_in;
         nz1_ff <= nz1_in;
         fw1_ff <= fw1_in;
         fg1_ff <= fg1_in;
         op2_ff <= op2_in;
         tw2_ff <= tw2_in;
         g0_ff  <= g0_in;
         g1_ff  <= g1_in;
         g2_ff  <= g2_in;
         nx2_ff <= nx2_in;
         ny2_ff <= ny2_in;
         nz2_ff <= nz2_in;
         fw2_ff <= fw2_in;
         fg2_ff <= fg2_in;
         op3_ff <= op3_in;
         tw3_ff <= tw3_in;
         e0_ff  <= e0_in;
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         fw3_ff <= fw3_in;
         fg3_ff <= fg3_in;
         op4_ff <= op4_in;
         tw4_ff <= tw4_in;
         m0_ff  <= m0_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         fw4_ff <= fw4_in;
         fg4_ff <= fg4_in;
         w_ff   <= w_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid    = ov_ff;
   assign weight_value = w_ff;
   assign saturated    = sat_ff;

endmodule
`default_nettype wire

/* design/chebyshev_interpolation_weight.sv */
// Top level of the Chebyshev interpolation weight block: config registers,
// three axis pipelines and the combine stage. Uses ciw_pkg, ciw_axis, ciw_comb.
//
// Each request beat carries a Gauss point, a surface normal and one Chebyshev
// node; the block maps the point into the box frame with the configured centre
// and reciprocal half size, evaluates the first- and second-kind Chebyshev
// series per axis up to ORDER terms, and returns one response beat: the plain
// weight (opcode 0), the normal derivative (1) or its negation (2); opcode 3
// returns zero. Results are Q16.16 and saturate, raising rsp_saturated. The
// datapath is a fully pipelined chain with one recurrence term per stage, so a
// new beat is taken every cycle unless the response is stalled. From accept to
// rsp_valid a beat passes three stages of mapping, ORDER - 1 series stages,
// five stages of divide by ORDER per axis and five combine stages. The whole
// pipeline advances while the response register is empty or being taken, so a
// back-pressured response freezes every stage in place. Configuration writes
// through csr_* take effect at once and must only happen while no beat is in
// flight.
`default_nettype none
`include "chebyshev_interpolation_weight_defines.svh"
module chebyshev_interpolation_weight #(
   parameter int ORDER = ciw_pkg::ORDER_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic signed [31:0]                req_point_x,
   input  logic signed [31:0]                req_point_y,
   input  logic signed [31:0]                req_point_z,
   input  logic signed [31:0]                req_normal_x,
   input  logic signed [31:0]                req_normal_y,
   input  logic signed [31:0]                req_normal_z,
   input  logic signed [31:0]                req_node_x,
   input  logic signed [31:0]                req_node_y,
   input  logic signed [31:0]                req_node_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_weight_value,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [ciw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);
   import ciw_pkg::*;

   // ---- configuration registers ----
   logic signed [31:0] centre_x_ff, centre_x_in;
   logic signed [31:0] centre_y_ff, centre_y_in;
   logic signed [31:0] centre_z_ff, centre_z_in;
   logic [30:0]        scale_x_ff, scale_x_in;
   logic [30:0]        scale_y_ff, scale_y_in;
   logic [30:0]        scale_z_ff, scale_z_in;

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      centre_z_in = centre_z_ff;
      scale_x_in  = scale_x_ff;
      scale_y_in  = scale_y_ff;
      scale_z_in  = scale_z_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_CENTRE_X: centre_x_in = csr_wdata;
            REG_CENTRE_Y: centre_y_in = csr_wdata;
            REG_CENTRE_Z: centre_z_in = csr_wdata;
            REG_SCALE_X:  scale_x_in  = csr_wdata[30:0];
            REG_SCALE_Y:  scale_y_in  = csr_wdata[30:0];
            REG_SCALE_Z:  scale_z_in  = csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         centre_z_ff <= '0;
         scale_x_ff  <= SCALE_RESET;
         scale_y_ff  <= SCALE_RESET;
         scale_z_ff  <= SCALE_RESET;
      end else begin
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         centre_z_ff <= centre_z_in;
         scale_x_ff  <= scale_x_in;
         scale_y_ff  <= scale_y_in;
         scale_z_ff  <= scale_z_in;
      end
   end

   // ---- pipeline advance: move unless the response register is stuck ----
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   logic     in_beat;
   side_type side_x, side_y, side_z;
   assign in_beat = req_valid & req_ready;
   assign side_x  = '{opcode: req_opcode, normal: req_normal_x};
   assign side_y  = '{opcode: req_opcode, normal: req_normal_y};
   assign side_z  = '{opcode: req_opcode, normal: req_normal_z};

   // ---- three axis pipelines ----
   logic               vx, vy, vz;
   logic signed [31:0] sx_value, sy_value, sz_value;
   logic signed [31:0] dx_value, dy_value, dz_value;
   logic               fx, fy, fz;
   side_type           ox, oy, oz;

   ciw_axis #(.ORDER(ORDER)) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_beat),
      .point     (req_point_x),
      .centre    (centre_x_ff),
      .scale     (scale_x_ff),
      .node      (req_node_x),
      .in_side   (side_x),
      .out_valid (vx),
      .s_value   (sx_value),
      .ds_value  (dx_value),
      .out_flag  (fx),
      .out_side  (ox)
   );

   ciw_axis #(.ORDER(ORDER)) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_beat),
      .point     (req_point_y),
      .centre    (centre_y_ff),
      .scale     (scale_y_ff),
      .node      (req_node_y),
      .in_side   (side_y),
      .out_valid (vy),
      .s_value   (sy_value),
      .ds_value  (dy_value),
      .out_flag  (fy),
      .out_side  (oy)
   );

   ciw_axis #(.ORDER(ORDER)) u_axis_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_beat),
      .point     (req_point_z),
      .centre    (centre_z_ff),
      .scale     (scale_z_ff),
      .node      (req_node_z),
      .in_side   (side_z),
      .out_valid (vz),
      .s_value   (sz_value),
      .ds_value  (dz_value),
      .out_flag  (fz),
      .out_side  (oz)
   );

   // ---- combine and response register ----
   ciw_comb u_comb (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (vx & vy & vz),
      .sx           (sx_value),
      .sy           (sy_value),
      .sz           (sz_value),
      .dx           (dx_value),
      .dy           (dy_value),
      .dz           (dz_value),
      .in_flag      (fx | fy | fz),
      .opcode       (ox.opcode),
      .normal_x     (ox.normal),
      .normal_y     (oy.normal),
      .normal_z     (oz.normal),
      .scale_x      (scale_x_ff),
      .scale_y      (scale_y_ff),
      .scale_z      (scale_z_ff),
      .out_valid    (rsp_valid),
      .weight_value (rsp_weight_value),
      .saturated    (rsp_saturated)
   );

   // ---- checks ----
   // the three axis pipelines must stay in lockstep
   `CIW_ASSERT_IMP(a_axes_lockstep, clock, reset, 1'b1, (vx == vy) && (vy == vz))
   // a held response freezes the axis pipelines
   `CIW_ASSERT_NXT(a_stall_freezes, clock, reset, rsp_valid && !rsp_ready, $stable(vx) && $stable(sx_value))

endmodule
`default_nettype wire
